/* hw/rtl/tpfp_pkg.sv */
// ----------------------------------------------------------------------------
// tpfp_pkg
// shared constants for the tftp packet field parser: byte roles, verdicts,
// opcodes and string phases
// ----------------------------------------------------------------------------
`default_nettype none

package tpfp_pkg;

	// byte roles
	localparam logic [3:0] ROLE_OPCODE    = 4'd0;
	localparam logic [3:0] ROLE_NUM_HI    = 4'd1;
	localparam logic [3:0] ROLE_NUM_LO    = 4'd2;
	localparam logic [3:0] ROLE_FNAME     = 4'd3;
	localparam logic [3:0] ROLE_FNAME_NUL = 4'd4;
	localparam logic [3:0] ROLE_MODE      = 4'd5;
	localparam logic [3:0] ROLE_MODE_NUL  = 4'd6;
	localparam logic [3:0] ROLE_DATA      = 4'd7;
	localparam logic [3:0] ROLE_MSG       = 4'd8;
	localparam logic [3:0] ROLE_MSG_NUL   = 4'd9;
	localparam logic [3:0] ROLE_IGNORED   = 4'd10;

	// packet verdicts
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_TOO_SHORT   = 3'd1;
	localparam logic [2:0] ST_UNKNOWN_OP  = 3'd2;
	localparam logic [2:0] ST_NUM_SHORT   = 3'd3;
	localparam logic [2:0] ST_NO_FNAME_NUL = 3'd4;
	localparam logic [2:0] ST_NO_MODE_NUL = 3'd5;
	localparam logic [2:0] ST_ERR_SHORT   = 3'd6;
	localparam logic [2:0] ST_NO_MSG_NUL  = 3'd7;

	// accepted opcodes
	localparam logic [15:0] OP_RRQ   = 16'd1;
	localparam logic [15:0] OP_DATA  = 16'd3;
	localparam logic [15:0] OP_ACK   = 16'd4;
	localparam logic [15:0] OP_ERROR = 16'd5;

	// byte position saturates here
	localparam logic [2:0] POS_MAX = 3'd5;

	// string phases; the fourth code is never reached and counts as done
	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_DONE   = 2'd2;

	localparam logic [7:0] NUL = 8'h00;

	function automatic logic has_number(input logic [15:0] op);
		return (op == OP_DATA) || (op == OP_ACK) || (op == OP_ERROR);
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/tftp_packet_field_parser.sv */
// ----------------------------------------------------------------------------
// tftp_packet_field_parser
// tags each byte of a tftp packet with its field and gives a verdict on the
// last byte
// ----------------------------------------------------------------------------
// Bytes of a packet enter one word per cycle on the item channel while
// item_stall is low, is_last set on the final byte. Every byte comes back on
// the result channel with its role (opcode, block number or error code,
// filename, mode, data, message, terminator, ignored), the opcode and number
// assembled so far, and on the last byte a verdict. The block sustains one
// byte per clock while result_stall is low, through an input register, then
// position, phase and field decode that also updates the per-packet state,
// then the result register; that update does not hold up the next byte. All
// packet state returns to zero after the last byte, so the next byte starts
// a new packet. Only RRQ, DATA, ACK and ERROR are accepted; WRQ and all
// other opcodes are reported as unknown.
`default_nettype none

module tftp_packet_field_parser import tpfp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// item channel
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [7:0]  byte_in,
	input  wire logic        is_last,
	// result channel
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [3:0]       byte_role,
	output logic [7:0]       byte_out,
	output logic [15:0]      packet_opcode,
	output logic [15:0]      number_value,
	output logic             packet_end,
	output logic [2:0]       parse_status
);

	// pipeline control
	logic valid_s1;
	logic adv_s2;   // result register loads
	logic adv_s1;   // input register loads

	assign adv_s2     = !result_valid || !result_stall;
	assign adv_s1     = !valid_s1 || adv_s2;
	assign item_stall = !adv_s1;

	// input register
	logic [7:0] byte_s1;
	logic       last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item_valid) begin
			byte_s1 <= byte_in;
			last_s1 <= is_last;
		end
	end

	// per-packet state
	logic [2:0]  pos_q;
	logic [15:0] opcode_q;
	logic [15:0] number_q;
	logic [1:0]  phase_q;

	// decode of the byte in the input register
	logic [15:0] opcode_nx;
	logic [15:0] number_nx;
	logic [1:0]  phase_nx;
	logic [3:0]  role_nx;
	logic [2:0]  status_nx;
	logic        is_nul;

	assign is_nul = (byte_s1 == NUL);

	always_comb begin
		opcode_nx = opcode_q;
		number_nx = number_q;
		phase_nx  = phase_q;
		role_nx   = ROLE_IGNORED;

		if (pos_q == 3'd0) begin
			// first opcode byte lands high, low half cleared
			opcode_nx = {byte_s1, 8'h00};
			role_nx   = ROLE_OPCODE;
		end else if (pos_q == 3'd1) begin
			opcode_nx = opcode_q | {8'h00, byte_s1};
			role_nx   = ROLE_OPCODE;
		end else if (opcode_q == OP_RRQ) begin
			// filename, then mode, each closed by a nul
			if (phase_q == PH_FIRST) begin
				role_nx = is_nul ? ROLE_FNAME_NUL : ROLE_FNAME;
				if (is_nul) begin
					phase_nx = PH_SECOND;
				end
			end else if (phase_q == PH_SECOND) begin
				role_nx = is_nul ? ROLE_MODE_NUL : ROLE_MODE;
				if (is_nul) begin
					phase_nx = PH_DONE;
				end
			end
		end else if (has_number(opcode_q)) begin
			if (pos_q == 3'd2) begin
				number_nx = {byte_s1, 8'h00};
				role_nx   = ROLE_NUM_HI;
			end else if (pos_q == 3'd3) begin
				number_nx = number_q | {8'h00, byte_s1};
				role_nx   = ROLE_NUM_LO;
			end else if (opcode_q == OP_DATA) begin
				role_nx = ROLE_DATA;
			end else if (opcode_q == OP_ERROR && phase_q == PH_FIRST) begin
				// error message runs to its first nul
				role_nx = is_nul ? ROLE_MSG_NUL : ROLE_MSG;
				if (is_nul) begin
					phase_nx = PH_DONE;
				end
			end
		end
	end

	// verdict, only on the last byte; shortness wins over everything else
	always_comb begin
		status_nx = ST_OK;
		if (last_s1) begin
			priority if (pos_q == 3'd0) begin
				status_nx = ST_TOO_SHORT;
			end else if (opcode_nx == OP_RRQ) begin
				if (phase_nx == PH_FIRST) begin
					status_nx = ST_NO_FNAME_NUL;
				end else if (phase_nx == PH_SECOND) begin
					status_nx = ST_NO_MODE_NUL;
				end
			end else if (opcode_nx == OP_DATA || opcode_nx == OP_ACK) begin
				if (pos_q < 3'd3) begin
					status_nx = ST_NUM_SHORT;
				end
			end else if (opcode_nx == OP_ERROR) begin
				if (pos_q < 3'd4) begin
					status_nx = ST_ERR_SHORT;
				end else if (phase_nx == PH_FIRST) begin
					status_nx = ST_NO_MSG_NUL;
				end
			end else begin
				status_nx = ST_UNKNOWN_OP;
			end
		end
	end

	// state update when the byte moves into the result register
	logic take_s1;
	assign take_s1 = valid_s1 && adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 3'd0;
			opcode_q <= 16'd0;
			number_q <= 16'd0;
			phase_q  <= PH_FIRST;
		end else if (take_s1) begin
			if (last_s1) begin
				// packet closed, start over
				pos_q    <= 3'd0;
				opcode_q <= 16'd0;
				number_q <= 16'd0;
				phase_q  <= PH_FIRST;
			end else begin
				opcode_q <= opcode_nx;
				number_q <= number_nx;
				phase_q  <= phase_nx;
				if (pos_q < POS_MAX) begin
					pos_q <= pos_q + 3'd1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv_s2) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			byte_role     <= role_nx;
			byte_out      <= byte_s1;
			packet_opcode <= opcode_nx;
			number_value  <= number_nx;
			packet_end    <= last_s1;
			parse_status  <= status_nx;
		end
	end

	// a verdict only ever rides on the closing byte
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !packet_end |-> parse_status == ST_OK)
		else $error("verdict on a byte that does not close the packet");

	// closing a packet clears the position
	assert property (@(posedge clk) disable iff (!arst_n)
		take_s1 && last_s1 |=> pos_q == 3'd0 && phase_q == PH_FIRST)
		else $error("packet state not cleared after last byte");

	// position never runs past its saturation point
	assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_MAX)
		else $error("byte position out of range");

	// opcodes without a number never show one
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !has_number(packet_opcode) |-> number_value == 16'd0)
		else $error("number reported for an opcode that has none");

	// a stalled result holds its role
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(byte_role))
		else $error("stalled result changed");

endmodule

`default_nettype wire
